// File: rtl/core/mtxq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the mutex unit with FIFO waiters.
// Holds the request/response payload structs and the operation and status codes.
// No dependencies.
package mtxq_pkg;

    localparam int NUM_LOCKS_DEF  = 16;
    localparam int POOL_NODES_DEF = 256;
    localparam int TASK_BITS_DEF  = 8;

    localparam logic [1:0] OP_TRY    = 2'd0;
    localparam logic [1:0] OP_LOCK   = 2'd1;
    localparam logic [1:0] OP_UNLOCK = 2'd2;

    localparam logic [2:0] ST_ACQUIRED = 3'd0;
    localparam logic [2:0] ST_BUSY     = 3'd1;
    localparam logic [2:0] ST_QUEUED   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_RELEASED = 3'd4;
    localparam logic [2:0] ST_HANDOFF  = 3'd5;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] lock_id;
        logic [7:0] task_id;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] woken_task;
        logic [8:0] nodes_in_use;
    } resp_t;

endpackage

// File: rtl/core/mutex_unit_with_fifo_waiters_top.sv
`timescale 1ns / 1ps
// Top level of the mutex unit with FIFO waiters: lock table, per-lock wait
// queues and the shared waiter node pool, run by one sequencer.
// Depends on mtxq_pkg.
//
// Lock manager for NUM_LOCKS locks sharing a pool of POOL_NODES waiter nodes.
// Each request carries an operation (try lock, lock or wait, unlock), a lock
// and a task id, and produces exactly one response. A try lock takes a free
// lock or answers busy. A lock request takes a free lock or appends the task
// to that lock's FIFO wait list; with every node in use the request is
// dropped and answered pool full. An unlock hands the lock to the oldest
// waiter and returns its task id, or frees the lock when nobody waits.
// Requests are handled one at a time: in_ready is high only while the
// sequencer is idle. A request passes through the lookup and execute states
// (and for a hand-off the node read and pop states) to the done state, which
// waits for the output register to be free, loads it and returns in_ready.
// The states follow the registered read ports of the queue and node
// memories: head/tail lookup, then for a hand-off a second dependent read of
// the head node. A finished response sits in the output register, and the
// next request may be accepted while it waits there.
// Free nodes come from a stack of released nodes, else from a counter of
// never-used nodes, so no clearing pass is needed after reset.
module mutex_unit_with_fifo_waiters_top
    import mtxq_pkg::*;
#(
    parameter int NUM_LOCKS  = NUM_LOCKS_DEF,
    parameter int POOL_NODES = POOL_NODES_DEF,
    parameter int TASK_BITS  = TASK_BITS_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  req_t  in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output resp_t out_data
);

    localparam int LIDX_W = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int NODE_W = $clog2(POOL_NODES);
    localparam int CNT_W  = $clog2(POOL_NODES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_EXEC,
        S_NODE,
        S_POP,
        S_DONE
    } state_t;

    // Sequencer and request registers
    state_t                 state_reg, state_next;
    logic [1:0]             op_reg, op_next;
    logic [3:0]             lock_reg, lock_next;
    logic [TASK_BITS-1:0]   task_reg, task_next;

    // Per-lock flags, cleared by reset
    logic [NUM_LOCKS-1:0]   held_reg, held_next;
    logic [NUM_LOCKS-1:0]   nonempty_reg, nonempty_next;

    // Pool bookkeeping
    logic [CNT_W-1:0]       used_reg, used_next;
    logic [CNT_W-1:0]       fresh_reg, fresh_next;
    logic [CNT_W-1:0]       free_sp_reg, free_sp_next;

    // Response in progress and output register
    logic [2:0]             status_reg, status_next;
    logic [TASK_BITS-1:0]   woken_reg, woken_next;
    logic                   out_valid_reg, out_valid_next;
    resp_t                  out_data_reg, out_data_next;

    // Memories: per-lock queue ends, node pool, free node stack
    logic [NODE_W-1:0]      head_mem [NUM_LOCKS];
    logic [NODE_W-1:0]      tail_mem [NUM_LOCKS];
    logic [TASK_BITS-1:0]   ntask_mem [POOL_NODES];
    logic [NODE_W-1:0]      nnext_mem [POOL_NODES];
    logic [NODE_W-1:0]      free_mem [POOL_NODES];

    logic [NODE_W-1:0]      head_rd, tail_rd, free_rd, nnext_rd;
    logic [TASK_BITS-1:0]   ntask_rd;

    // Memory write controls
    logic                   head_we, tail_we, ntask_we, nnext_we, free_we;
    logic [NODE_W-1:0]      head_wdata, tail_wdata, nnext_wdata, free_wdata;
    logic [NODE_W-1:0]      ntask_waddr, nnext_waddr, free_waddr;

    // Decode helpers
    logic [8:0]             lock_ext;
    logic [LIDX_W-1:0]      lock_idx;
    logic                   in_range;
    logic [CNT_W-1:0]       free_sp_dec;
    logic [NODE_W-1:0]      free_raddr;
    logic [NODE_W-1:0]      alloc_node;
    logic                   pool_full;
    logic [TASK_BITS+7:0]   task_ext;
    logic [TASK_BITS+7:0]   woken_ext;
    logic [CNT_W+8:0]       used_ext;

    assign lock_ext    = {5'd0, lock_reg};
    assign lock_idx    = lock_ext[LIDX_W-1:0];
    assign in_range    = lock_ext < 9'(NUM_LOCKS);
    assign free_sp_dec = free_sp_reg - CNT_W'(1);
    assign free_raddr  = free_sp_dec[NODE_W-1:0];
    assign pool_full   = used_reg == CNT_W'(POOL_NODES);
    // Reuse a released node first, else take the next never-used one
    assign alloc_node  = (free_sp_reg != '0) ? free_rd : fresh_reg[NODE_W-1:0];
    assign task_ext    = {{TASK_BITS{1'b0}}, in_data.task_id};
    assign woken_ext   = {8'd0, woken_reg};
    assign used_ext    = {9'd0, used_reg};

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        lock_next      = lock_reg;
        task_next      = task_reg;
        held_next      = held_reg;
        nonempty_next  = nonempty_reg;
        used_next      = used_reg;
        fresh_next     = fresh_reg;
        free_sp_next   = free_sp_reg;
        status_next    = status_reg;
        woken_next     = woken_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        head_we     = 1'b0;
        tail_we     = 1'b0;
        ntask_we    = 1'b0;
        nnext_we    = 1'b0;
        free_we     = 1'b0;
        head_wdata  = alloc_node;
        tail_wdata  = alloc_node;
        nnext_wdata = alloc_node;
        nnext_waddr = tail_rd;
        ntask_waddr = alloc_node;
        free_wdata  = head_rd;
        free_waddr  = free_sp_reg[NODE_W-1:0];

        // Drop the response once the consumer takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_data.operation;
                    lock_next  = in_data.lock_id;
                    task_next  = task_ext[TASK_BITS-1:0];
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                // Queue head/tail and free stack top are read at this edge
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                status_next = ST_BUSY;
                woken_next  = '0;
                state_next  = S_DONE;
                if (in_range)
                begin
                    case (op_reg)
                        OP_TRY:
                        begin
                            if (!held_reg[lock_idx])
                            begin
                                held_next[lock_idx] = 1'b1;
                                status_next         = ST_ACQUIRED;
                            end
                        end
                        OP_LOCK:
                        begin
                            if (!held_reg[lock_idx])
                            begin
                                held_next[lock_idx] = 1'b1;
                                status_next         = ST_ACQUIRED;
                            end
                            else if (pool_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                // Append a node to the lock's wait list
                                ntask_we  = 1'b1;
                                tail_we   = 1'b1;
                                used_next = used_reg + CNT_W'(1);
                                if (free_sp_reg != '0)
                                begin
                                    free_sp_next = free_sp_dec;
                                end
                                else
                                begin
                                    fresh_next = fresh_reg + CNT_W'(1);
                                end
                                if (nonempty_reg[lock_idx])
                                begin
                                    nnext_we = 1'b1;
                                end
                                else
                                begin
                                    head_we                 = 1'b1;
                                    nonempty_next[lock_idx] = 1'b1;
                                end
                                status_next = ST_QUEUED;
                            end
                        end
                        OP_UNLOCK:
                        begin
                            if (nonempty_reg[lock_idx])
                            begin
                                state_next = S_NODE;
                            end
                            else
                            begin
                                held_next[lock_idx] = 1'b0;
                                status_next         = ST_RELEASED;
                            end
                        end
                        default:
                        begin
                            status_next = ST_BUSY;
                        end
                    endcase
                end
            end
            S_NODE:
            begin
                // Head node task and link are read at this edge
                state_next = S_POP;
            end
            S_POP:
            begin
                woken_next  = ntask_rd;
                status_next = ST_HANDOFF;
                if (head_rd == tail_rd)
                begin
                    nonempty_next[lock_idx] = 1'b0;
                end
                else
                begin
                    head_we    = 1'b1;
                    head_wdata = nnext_rd;
                end
                // Return the node to the free stack
                free_we      = 1'b1;
                free_sp_next = free_sp_reg + CNT_W'(1);
                used_next    = used_reg - CNT_W'(1);
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.status       = status_reg;
                    out_data_next.woken_task   = woken_ext[7:0];
                    out_data_next.nodes_in_use = used_ext[8:0];
                    out_valid_next             = 1'b1;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= '0;
            lock_reg      <= '0;
            task_reg      <= '0;
            held_reg      <= '0;
            nonempty_reg  <= '0;
            used_reg      <= '0;
            fresh_reg     <= '0;
            free_sp_reg   <= '0;
            status_reg    <= '0;
            woken_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            lock_reg      <= lock_next;
            task_reg      <= task_next;
            held_reg      <= held_next;
            nonempty_reg  <= nonempty_next;
            used_reg      <= used_next;
            fresh_reg     <= fresh_next;
            free_sp_reg   <= free_sp_next;
            status_reg    <= status_next;
            woken_reg     <= woken_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // Queue end memories: one write each, registered read at the request's lock
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[lock_idx] <= head_wdata;
        end
        if (tail_we)
        begin
            tail_mem[lock_idx] <= tail_wdata;
        end
        head_rd <= head_mem[lock_idx];
        tail_rd <= tail_mem[lock_idx];
    end

    // Node pool: task and link, registered read at the queue head
    always_ff @(posedge clk)
    begin
        if (ntask_we)
        begin
            ntask_mem[ntask_waddr] <= task_reg;
        end
        if (nnext_we)
        begin
            nnext_mem[nnext_waddr] <= nnext_wdata;
        end
        ntask_rd <= ntask_mem[head_rd];
        nnext_rd <= nnext_mem[head_rd];
    end

    // Free node stack, registered read of the top entry
    always_ff @(posedge clk)
    begin
        if (free_we)
        begin
            free_mem[free_waddr] <= free_wdata;
        end
        free_rd <= free_mem[free_raddr];
    end

endmodule

// File: bench/mtxq_lock_checker.sv
`timescale 1ns / 1ps
// Response checker for the mutex unit with FIFO waiters: keeps its own lock
// table and per-lock wait lists, predicts each response and compares fields.
// Depends on mtxq_pkg.
module mtxq_lock_checker
    import mtxq_pkg::*;
#(
    parameter int NUM_LOCKS  = NUM_LOCKS_DEF,
    parameter int POOL_NODES = POOL_NODES_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  in_ready,
    input  req_t  in_data,
    input  logic  out_valid,
    input  logic  out_ready,
    input  resp_t out_data,
    output int    fail_count
);

    // Lock ownership and one circular wait list per lock; the shared pool
    // limit is enforced through waiters_total.
    logic       held    [NUM_LOCKS];
    logic [7:0] waiter  [NUM_LOCKS][POOL_NODES];
    int         wr_ptr  [NUM_LOCKS];
    int         rd_ptr  [NUM_LOCKS];
    int         depth   [NUM_LOCKS];
    int         waiters_total;
    resp_t      due_responses[$];

    function automatic resp_t lock_table_step(input req_t req);
        resp_t rsp;
        int    l;
        rsp.status     = ST_BUSY;
        rsp.woken_task = '0;
        l = int'(req.lock_id);
        if (l < NUM_LOCKS)
        begin
            case (req.operation)
                OP_TRY:
                begin
                    if (!held[l])
                    begin
                        held[l]    = 1'b1;
                        rsp.status = ST_ACQUIRED;
                    end
                end
                OP_LOCK:
                begin
                    if (!held[l])
                    begin
                        held[l]    = 1'b1;
                        rsp.status = ST_ACQUIRED;
                    end
                    else if (waiters_total >= POOL_NODES)
                        rsp.status = ST_FULL;
                    else
                    begin
                        waiter[l][wr_ptr[l]] = req.task_id;
                        wr_ptr[l]     = (wr_ptr[l] + 1) % POOL_NODES;
                        depth[l]      = depth[l] + 1;
                        waiters_total = waiters_total + 1;
                        rsp.status    = ST_QUEUED;
                    end
                end
                OP_UNLOCK:
                begin
                    if (depth[l] != 0)
                    begin
                        // hand the lock to the oldest waiter; lock stays held
                        rsp.woken_task = waiter[l][rd_ptr[l]];
                        rd_ptr[l]     = (rd_ptr[l] + 1) % POOL_NODES;
                        depth[l]      = depth[l] - 1;
                        waiters_total = waiters_total - 1;
                        rsp.status    = ST_HANDOFF;
                    end
                    else
                    begin
                        held[l]    = 1'b0;
                        rsp.status = ST_RELEASED;
                    end
                end
                default: ;
            endcase
        end
        rsp.nodes_in_use = waiters_total[8:0];
        return rsp;
    endfunction

    // Sample mid-cycle: both handshakes are stable between rising edges.
    always @(negedge clk or negedge rst_n)
    begin : watch_channels
        resp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LOCKS; i++)
            begin
                held[i]   = 1'b0;
                wr_ptr[i] = 0;
                rd_ptr[i] = 0;
                depth[i]  = 0;
            end
            waiters_total = 0;
            due_responses.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_responses.size() == 0)
                begin
                    $display("%0t: response with none outstanding, actual status %0d",
                             $time, out_data.status);
                    fail_count++;
                end
                else
                begin
                    want = due_responses.pop_front();
                    if (out_data.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, out_data.status);
                        fail_count++;
                    end
                    if (out_data.woken_task !== want.woken_task)
                    begin
                        $display("%0t: woken_task mismatch, expected %0d, actual %0d",
                                 $time, want.woken_task, out_data.woken_task);
                        fail_count++;
                    end
                    if (out_data.nodes_in_use !== want.nodes_in_use)
                    begin
                        $display("%0t: nodes_in_use mismatch, expected %0d, actual %0d",
                                 $time, want.nodes_in_use, out_data.nodes_in_use);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                due_responses.push_back(lock_table_step(in_data));
        end
    end

endmodule

// File: bench/mutex_unit_with_fifo_waiters_top_tb.sv
`timescale 1ns / 1ps
// Top of the bench for the mutex unit with FIFO waiters: clock, reset,
// request stimulus, response sink with stalls, watchdog and verdict.
// Depends on mtxq_pkg, mtxq_lock_checker and the block's top level.
module mutex_unit_with_fifo_waiters_top_tb;
    import mtxq_pkg::*;

    // Operation code the block must ignore (answers busy, changes nothing).
    localparam logic [1:0] OP_NONE = 2'd3;

    // Longest run of cycles with no handshake on either side before the run
    // is declared hung. The long receiver hold-off is well below it.
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 20;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_ready;
    req_t  in_data;
    logic  out_valid;
    logic  out_ready;
    resp_t out_data;

    int fail_count;
    int n_sent       = 0;
    int n_recv       = 0;
    int quiet_cycles = 0;
    bit in_burst     = 1'b0;
    bit out_burst    = 1'b0;
    bit hold_out     = 1'b0;

    mutex_unit_with_fifo_waiters_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    mtxq_lock_checker lock_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .fail_count (fail_count)
    );

    // 4 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Offer one request and return at the rising edge that accepts it.
    // Valid is left high on return, so a back-to-back request only replaces
    // the payload; a gap or a pause lowers valid in that same step.
    task automatic send_req(input logic [1:0] op, input logic [3:0] lk,
                            input logic [7:0] tk);
        req_t req;
        int   gap;
        req.operation = op;
        req.lock_id   = lk;
        req.task_id   = tk;
        // switch between bursts with no gaps and randomly drawn gaps
        if ($urandom_range(0, 31) == 0)
            in_burst = !in_burst;
        gap = in_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        // ready is checked mid-cycle; the following rising edge accepts
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        n_sent++;
    endtask

    // Drop valid and hold off until every outstanding response has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (n_recv != n_sent)
            @(posedge clk);
    endtask

    // Request side: directed checks, a long random mix, then a pass that
    // fills the whole waiter pool and drains it again.
    initial
    begin : stimulus
        logic [1:0] op;
        logic [3:0] lk;
        int         pick;
        bit         narrow;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Try-lock on a free and a held lock, three waiters with extreme
        // task ids, hand-offs in FIFO order down to the last waiter, then a
        // plain release and an unlock of a lock that is already free.
        send_req(OP_TRY,    4'd0,  8'h11);
        send_req(OP_TRY,    4'd0,  8'h22);
        send_req(OP_LOCK,   4'd0,  8'hFF);
        send_req(OP_LOCK,   4'd0,  8'h00);
        send_req(OP_LOCK,   4'd0,  8'hA5);
        send_req(OP_UNLOCK, 4'd0,  8'h00);
        send_req(OP_UNLOCK, 4'd0,  8'h00);
        send_req(OP_UNLOCK, 4'd0,  8'h00);
        send_req(OP_UNLOCK, 4'd0,  8'h00);
        send_req(OP_UNLOCK, 4'd0,  8'hFF);
        // Highest lock, lock-or-wait on a free lock, the unknown operation
        // on a held and a free lock.
        send_req(OP_LOCK,   4'd15, 8'h5A);
        send_req(OP_LOCK,   4'd15, 8'h80);
        send_req(OP_NONE,   4'd15, 8'h7F);
        send_req(OP_NONE,   4'd0,  8'h00);
        send_req(OP_UNLOCK, 4'd15, 8'h01);
        send_req(OP_UNLOCK, 4'd15, 8'h02);
        send_req(OP_TRY,    4'd15, 8'hFE);
        send_req(OP_UNLOCK, 4'd15, 8'h00);
        // Two locks with waiters at once, interleaved.
        send_req(OP_LOCK,   4'd7,  8'h01);
        send_req(OP_LOCK,   4'd8,  8'h02);
        send_req(OP_LOCK,   4'd7,  8'h03);
        send_req(OP_LOCK,   4'd8,  8'h04);
        send_req(OP_TRY,    4'd7,  8'h05);
        send_req(OP_UNLOCK, 4'd8,  8'h00);
        send_req(OP_UNLOCK, 4'd7,  8'h00);
        wait_drained();

        // Random mix. Lock requests outweigh unlocks so wait lists grow;
        // half the time requests crowd onto four locks to build long lists.
        narrow = 1'b0;
        for (int i = 0; i < 1200; i++)
        begin
            if (i % 100 == 0)
                narrow = 1'($urandom_range(0, 1));
            // receiver holds off once while requests keep coming
            if (i == 400)
                hold_out = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 8)
                op = OP_NONE;
            else if (pick < 23)
                op = OP_TRY;
            else if (pick < 65)
                op = OP_LOCK;
            else
                op = OP_UNLOCK;
            lk = narrow ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
            send_req(op, lk, 8'($urandom_range(0, 255)));
        end

        // Pause until idle, then flood lock requests: with at most 16 grants
        // the rest overrun the 256-node pool and must come back pool full.
        wait_drained();
        for (int i = 0; i < 320; i++)
        begin
            if (i == 150)
                hold_out = 1'b1;
            send_req(OP_LOCK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        end
        // drain the lists by random unlocks; late ones release free locks
        for (int i = 0; i < 400; i++)
            send_req(OP_UNLOCK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Response side: a random stall before each response, with stretches of no
    // stalling, and one long hold-off whenever the stimulus asks for it.
    initial
    begin : response_sink
        int gap;
        out_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                out_burst = !out_burst;
            gap = out_burst ? 0 : $urandom_range(0, 8);
            if (hold_out)
            begin
                gap      = LONG_HOLD;
                hold_out = 1'b0;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(negedge clk);
            while (!out_valid)
                @(negedge clk);
            @(posedge clk);
            n_recv++;
        end
    end

    // Watchdog: count cycles with no handshake on either channel.
    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
